// ===== design/shu_pkg.sv =====
// ----------------------------------------------------------------------------
// shu_pkg
// Shared types and constants for the symbol histogram unique-mode unit.
// ----------------------------------------------------------------------------
package shu_pkg;

	// Histogram geometry
	localparam int NUM_SYMBOLS = 256;
	localparam int COUNT_WIDTH = 16;
	localparam int SYM_WIDTH   = 8;
	localparam int IDX_WIDTH   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int TIE_WIDTH   = 9;
	localparam int SHOW_WIDTH  = 16;

	// Input item modes
	localparam logic MODE_COUNT = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// One input item
	typedef struct packed {
		logic                 mode;
		logic [SYM_WIDTH-1:0] residue;
	} shu_in_t;

	// One result item
	typedef struct packed {
		logic [SYM_WIDTH-1:0]  top_residue;
		logic                  unique_res;
		logic [SHOW_WIDTH-1:0] top_count;
	} shu_out_t;

	// Clamp a counter value to the reported count width
	function automatic logic [SHOW_WIDTH-1:0] shu_show(input logic [COUNT_WIDTH-1:0] cnt);
		logic [63:0] ext;
		ext = 64'(cnt);
		if (ext > 64'((64'd1 << SHOW_WIDTH) - 64'd1)) begin
			return {SHOW_WIDTH{1'b1}};
		end
		return ext[SHOW_WIDTH-1:0];
	endfunction

endpackage

// ===== design/symbol_histogram_unique_mode_unit.sv =====
// ----------------------------------------------------------------------------
// symbol_histogram_unique_mode_unit
// Per-symbol saturating histogram with a running most-popular-symbol tracker.
// ----------------------------------------------------------------------------
// Each transfer on the input either counts one symbol or clears the whole
// histogram, and yields exactly one result: the symbol with the greatest
// count (0 unless exactly one symbol holds it), a uniqueness flag and the
// greatest count. The block takes one item per clock cycle while the result
// register is free or being taken. An item waits in the read stage (counter
// memory read, registered) until the result register is free, then the
// update logic writes the counter back and refreshes the tracker into the
// result register. A counter written by the update stage and read by the
// next item in the same cycle is forwarded. Clearing is immediate: the
// per-symbol valid bits are all dropped at once, so no clearing pass
// follows reset or a clear item. Counters stick at their all-ones value.
module symbol_histogram_unique_mode_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  shu_pkg::shu_in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output shu_pkg::shu_out_t out_data
);
	import shu_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_LIMIT = {COUNT_WIDTH{1'b1}};

	// Counter storage and per-symbol valid bits
	logic [COUNT_WIDTH-1:0] cnt_mem [NUM_SYMBOLS];
	logic [NUM_SYMBOLS-1:0] cnt_vld_q;

	// Tracker state
	logic [COUNT_WIDTH-1:0] max_count_q;
	logic [SYM_WIDTH-1:0]   max_symbol_q;
	logic [TIE_WIDTH-1:0]   tie_total_q;

	// Read stage
	logic                   valid_s1;
	logic                   mode_s1;
	logic [SYM_WIDTH-1:0]   residue_s1;
	logic                   in_range_s1;
	logic [COUNT_WIDTH-1:0] rd_data_s1;
	logic                   rd_vld_s1;
	logic                   fwd_hit_s1;
	logic [COUNT_WIDTH-1:0] fwd_data_s1;

	// Result register
	logic     out_valid_q;
	shu_out_t out_q;

	logic                   in_fire;
	logic                   s1_go;
	logic                   in_range;
	logic [IDX_WIDTH-1:0]   in_idx;
	logic [IDX_WIDTH-1:0]   idx_s1;
	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic                   do_count;
	logic                   wr_en;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic [COUNT_WIDTH-1:0] max_count_d;
	logic [SYM_WIDTH-1:0]   max_symbol_d;
	logic [TIE_WIDTH-1:0]   tie_total_d;
	logic                   uniq_d;

	// Handshake
	assign s1_go     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || s1_go;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Address decode
	assign in_range = ({1'b0, in_data.residue} < 9'(NUM_SYMBOLS));
	assign in_idx   = IDX_WIDTH'(in_data.residue);
	assign idx_s1   = IDX_WIDTH'(residue_s1);

	// Current count: forwarded write, else stored value if valid, else zero
	always_comb begin
		if (fwd_hit_s1) begin
			cur_cnt = fwd_data_s1;
		end else if (rd_vld_s1) begin
			cur_cnt = rd_data_s1;
		end else begin
			cur_cnt = '0;
		end
	end

	// Counter update; a saturated counter writes back unchanged
	assign do_count = s1_go && (mode_s1 == MODE_COUNT) && in_range_s1;
	assign wr_en    = do_count;
	assign wr_data  = (cur_cnt == CNT_LIMIT) ? cur_cnt : cur_cnt + 1'b1;

	// Tracker next state
	always_comb begin
		max_count_d  = max_count_q;
		max_symbol_d = max_symbol_q;
		tie_total_d  = tie_total_q;
		if (mode_s1 == MODE_CLEAR) begin
			max_count_d  = '0;
			max_symbol_d = '0;
			tie_total_d  = '0;
		end else if (in_range_s1 && cur_cnt != CNT_LIMIT) begin
			if (wr_data > max_count_q) begin
				max_count_d  = wr_data;
				max_symbol_d = residue_s1;
				tie_total_d  = TIE_WIDTH'(1);
			end else if (wr_data == max_count_q) begin
				tie_total_d = tie_total_q + 1'b1;
			end
		end
	end

	assign uniq_d = (max_count_d != '0) && (tie_total_d == TIE_WIDTH'(1));

	// Memory write in the update stage, registered read at input transfer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[idx_s1] <= wr_data;
		end
		if (in_fire) begin
			rd_data_s1 <= cnt_mem[in_idx];
		end
	end

	// Valid bits: set on write, drop all on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (s1_go && mode_s1 == MODE_CLEAR) begin
			cnt_vld_q <= '0;
		end else if (wr_en) begin
			cnt_vld_q[idx_s1] <= 1'b1;
		end
	end

	// Read stage payload, with forwarding from the update stage
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1     <= in_data.mode;
			residue_s1  <= in_data.residue;
			in_range_s1 <= in_range;
			rd_vld_s1   <= cnt_vld_q[in_idx];
			fwd_hit_s1  <= s1_go && ((mode_s1 == MODE_CLEAR) || (wr_en && idx_s1 == in_idx));
			fwd_data_s1 <= (mode_s1 == MODE_CLEAR) ? '0 : wr_data;
		end
	end

	// Read stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Tracker and result occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q  <= '0;
			max_symbol_q <= '0;
			tie_total_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (s1_go) begin
				max_count_q  <= max_count_d;
				max_symbol_q <= max_symbol_d;
				tie_total_q  <= tie_total_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q.top_residue <= uniq_d ? max_symbol_d : '0;
			out_q.unique_res  <= uniq_d;
			out_q.top_count   <= shu_show(max_count_d);
		end
	end

endmodule

// ===== dv/tb_symbol_histogram_unique_mode_unit.sv =====
// ----------------------------------------------------------------------------
// tb_symbol_histogram_unique_mode_unit
// Self-checking bench for the symbol histogram with most-popular tracking.
// ----------------------------------------------------------------------------
// Count and clear items go in through a valid/ready channel. A behavioral
// copy of the histogram predicts the result of each item, and the results are
// compared field by field in order. The stimulus starts with a short table:
// field extremes, ties, clears, and a few hand-computed results. A sweep that
// ties all symbols follows, then a short run that piles counts on one symbol.
// The rest is bursts over small symbol pools, which make the
// uniqueness flag flip often, mixed with clears and single random counts.
// The random bursts are run again with idle sender and stalling receiver patterns.
// ----------------------------------------------------------------------------
module tb_symbol_histogram_unique_mode_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import shu_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 125;
	localparam int MAX_PRINTS   = 50;
	localparam int HOT_COUNTS   = 20;

	// One row of the directed table; want is used only when has_want is set
	typedef struct packed {
		shu_in_t  item;
		logic     has_want;
		shu_out_t want;
	} stim_row_t;

	localparam int NUM_ROWS = 16;
	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{'{MODE_COUNT, 8'h00}, 1'b1, '{8'h00, 1'b1, 16'd1}},
		'{'{MODE_COUNT, 8'hFF}, 1'b1, '{8'h00, 1'b0, 16'd1}},
		'{'{MODE_COUNT, 8'hFF}, 1'b1, '{8'hFF, 1'b1, 16'd2}},
		'{'{MODE_COUNT, 8'h00}, 1'b1, '{8'h00, 1'b0, 16'd2}},
		'{'{MODE_CLEAR, 8'hFF}, 1'b1, '{8'h00, 1'b0, 16'd0}},
		'{'{MODE_CLEAR, 8'h00}, 1'b1, '{8'h00, 1'b0, 16'd0}},
		'{'{MODE_COUNT, 8'h80}, 1'b1, '{8'h80, 1'b1, 16'd1}},
		'{'{MODE_COUNT, 8'h01}, 1'b1, '{8'h00, 1'b0, 16'd1}},
		'{'{MODE_COUNT, 8'h7F}, 1'b0, '0},
		'{'{MODE_COUNT, 8'h01}, 1'b0, '0},
		'{'{MODE_COUNT, 8'h80}, 1'b0, '0},
		'{'{MODE_COUNT, 8'h80}, 1'b0, '0},
		'{'{MODE_COUNT, 8'hAA}, 1'b0, '0},
		'{'{MODE_COUNT, 8'h55}, 1'b0, '0},
		'{'{MODE_CLEAR, 8'h5A}, 1'b1, '{8'h00, 1'b0, 16'd0}},
		'{'{MODE_COUNT, 8'h55}, 1'b1, '{8'h55, 1'b1, 16'd1}}
	};

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	shu_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	shu_out_t out_data;

	// Predicted histogram state
	logic [COUNT_WIDTH-1:0] hist_count [NUM_SYMBOLS];
	logic [COUNT_WIDTH-1:0] peak_count;
	logic [SYM_WIDTH-1:0]   peak_symbol;
	logic [TIE_WIDTH-1:0]   peak_ties;

	shu_out_t expected_tops [$];
	int       mismatch_count  = 0;
	int       quiet_cycles    = 0;
	int       send_idle_pct   = 0;
	int       recv_stall_pct  = 0;

	symbol_histogram_unique_mode_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	// Return the histogram and tracker to their empty state
	function automatic void clear_histogram();
		foreach (hist_count[i]) hist_count[i] = '0;
		peak_count  = '0;
		peak_symbol = '0;
		peak_ties   = '0;
	endfunction

	// Apply one item to the predicted state and return the result it yields
	function automatic shu_out_t predict_histogram(input shu_in_t item);
		logic [COUNT_WIDTH-1:0] next;
		shu_out_t res;
		if (item.mode == MODE_CLEAR) begin
			clear_histogram();
		end else if (int'(item.residue) < NUM_SYMBOLS && hist_count[item.residue] != '1) begin
			next = hist_count[item.residue] + 1'b1;
			hist_count[item.residue] = next;
			if (next > peak_count) begin
				peak_count  = next;
				peak_symbol = item.residue;
				peak_ties   = TIE_WIDTH'(1);
			end else if (next == peak_count) begin
				peak_ties = peak_ties + 1'b1;
			end
		end
		res.unique_res  = (peak_count != '0) && (peak_ties == TIE_WIDTH'(1));
		res.top_residue = res.unique_res ? peak_symbol : '0;
		if (64'(peak_count) > 64'((64'd1 << SHOW_WIDTH) - 64'd1))
			res.top_count = '1;
		else
			res.top_count = SHOW_WIDTH'(peak_count);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Hold valid and payload until the transfer; the expectation is queued first
	task automatic issue_item(input shu_in_t item, input shu_out_t want);
		expected_tops.push_back(want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_predicted(input logic mode, input logic [SYM_WIDTH-1:0] residue);
		shu_in_t item;
		item.mode    = mode;
		item.residue = residue;
		issue_item(item, predict_histogram(item));
	endtask

	// Bursts over small symbol pools, with clears and stray counts mixed in
	task automatic run_random(input int quota);
		int sent;
		int kind;
		int len;
		int pool_n;
		logic [SYM_WIDTH-1:0] pool [4];
		sent = 0;
		while (sent < quota) begin
			kind = $urandom_range(99);
			if (kind < 10) begin
				send_predicted(MODE_CLEAR, SYM_WIDTH'($urandom));
				sent++;
			end else if (kind < 25) begin
				send_predicted(MODE_COUNT, SYM_WIDTH'($urandom));
				sent++;
			end else begin
				pool_n = $urandom_range(1, 4);
				for (int i = 0; i < 4; i++) pool[i] = SYM_WIDTH'($urandom);
				len = $urandom_range(3, 24);
				for (int i = 0; i < len; i++)
					send_predicted(MODE_COUNT, pool[$urandom_range(0, pool_n - 1)]);
				sent += len;
				if ($urandom_range(1) == 1) begin
					send_predicted(MODE_CLEAR, SYM_WIDTH'($urandom));
					sent++;
				end
			end
		end
	endtask

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin : result_check
		shu_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tops.size() == 0) begin
				report_mismatch("unexpected result, top_count", out_data.top_count, -1);
			end else begin
				want = expected_tops.pop_front();
				if (out_data.top_residue !== want.top_residue)
					report_mismatch("top_residue", out_data.top_residue, want.top_residue);
				if (out_data.unique_res !== want.unique_res)
					report_mismatch("unique_res", out_data.unique_res, want.unique_res);
				if (out_data.top_count !== want.top_count)
					report_mismatch("top_count", out_data.top_count, want.top_count);
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Count cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("symbol_histogram_unique_mode_unit test failed");
		$finish;
	end

	initial begin
		int send_pcts [4];
		int recv_pcts [4];
		logic [SYM_WIDTH-1:0] hot;
		send_pcts = '{0, 75, 0, 28};
		recv_pcts = '{0, 0, 75, 28};
		clear_histogram();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = send_pcts[phase];
			recv_stall_pct = recv_pcts[phase];
			if (phase == 0) begin
				// Directed table; hand-computed rows are checked as typed
				for (int r = 0; r < NUM_ROWS; r++) begin
					shu_out_t want;
					want = predict_histogram(DIRECTED_ROWS[r].item);
					if (DIRECTED_ROWS[r].has_want)
						want = DIRECTED_ROWS[r].want;
					issue_item(DIRECTED_ROWS[r].item, want);
				end

				// Tie every symbol at one, then break the tie
				send_predicted(MODE_CLEAR, 8'h00);
				for (int s = 0; s < NUM_SYMBOLS; s++)
					send_predicted(MODE_COUNT, SYM_WIDTH'(s));
				send_predicted(MODE_COUNT, 8'h3C);
				send_predicted(MODE_CLEAR, 8'h00);

				// Pile counts on one symbol, then touch its complement
				hot = SYM_WIDTH'($urandom);
				for (int n = 0; n < HOT_COUNTS; n++)
					send_predicted(MODE_COUNT, hot);
				send_predicted(MODE_COUNT, hot ^ 8'hFF);
				send_predicted(MODE_COUNT, hot);
				send_predicted(MODE_CLEAR, hot);
			end
			run_random(RANDOM_ITEMS);
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then allow for the pipeline depth
		while (expected_tops.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("symbol_histogram_unique_mode_unit test passed");
		else
			$display("symbol_histogram_unique_mode_unit test failed");
		$finish;
	end

endmodule
